// ===== design/dersig_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dersig_pkg
// Shared types and constants for the DER signature parser.
// ----------------------------------------------------------------------------
package dersig_pkg;

    localparam int MAX_INPUT_BYTES = 256;
    localparam int LEN_MAX         = (MAX_INPUT_BYTES > 127) ? MAX_INPUT_BYTES : 127;
    localparam int LEN_W           = $clog2(LEN_MAX + 1);
    localparam int ACC_W           = LEN_W + 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int OUT_DATA_W = 40;

    localparam logic [7:0] TAG_SEQUENCE      = 8'h30;
    localparam logic [7:0] TAG_INTEGER       = 8'h02;
    localparam logic [7:0] LEN_BAD_INDEF     = 8'h80;
    localparam logic [7:0] LEN_BAD_RESERVED  = 8'hFF;
    localparam logic [6:0] LEN_LONG_MAX      = 7'd8;
    localparam logic [7:0] COUNT_MAX         = 8'd255;
    localparam logic [7:0] MAX_INT_LEN_RESET = 8'd32;
    localparam logic [ACC_W-1:0] LONG_FORM_MIN = ACC_W'(128);
    localparam logic [ACC_W-1:0] LEN_BOUND     = ACC_W'(MAX_INPUT_BYTES);

    typedef enum logic [2:0] {
        PH_SEQ_TAG,
        PH_SEQ_LEN,
        PH_SEQ_LEN_MORE,
        PH_INT_TAG,
        PH_INT_LEN,
        PH_INT_LEN_MORE,
        PH_INT_VAL,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_R       = 2'd0,
        KIND_S       = 2'd1,
        KIND_VERDICT = 2'd2
    } kind_t;

    // one queue entry: an optional value beat and an optional verdict beat
    typedef struct packed {
        logic       has_value;
        logic       is_s;
        logic [7:0] value_byte;
        logic [7:0] value_index;
        logic       has_verdict;
        logic       sig_ok;
        logic [7:0] r_length;
        logic [7:0] s_length;
    } rec_t;

endpackage

// ===== design/dersig_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dersig_front
// Byte parser: takes input beats, walks the DER structure and queues results.
// ----------------------------------------------------------------------------
module dersig_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,
    input  logic             s_axis_tlast,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata,
    input  logic             q_full,
    output logic             q_push,
    output dersig_pkg::rec_t q_rec
);
    import dersig_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] accum_reg, accum_next;
    logic [3:0]       lbytes_reg, lbytes_next;
    logic [LEN_W-1:0] seq_left_reg, seq_left_next;
    logic [LEN_W-1:0] int_left_reg, int_left_next;
    logic             isel_reg, isel_next;
    logic             first_reg, first_next;
    logic             lz_reg, lz_next;
    logic [7:0]       r_cnt_reg, r_cnt_next;
    logic [7:0]       s_cnt_reg, s_cnt_next;
    logic             err_reg, err_next;
    logic [7:0]       max_len_reg;

    logic             fire;
    logic [7:0]       b;
    logic             is_seq;
    logic             fin_en;
    logic [LEN_W-1:0] fin_len;
    logic             end_int;
    logic             emit;
    logic [7:0]       emit_index;
    logic [ACC_W-1:0] acc;
    logic [LEN_W-1:0] il_dec;
    logic [3:0]       lb_dec;
    logic             go;
    logic [7:0]       cnt;
    logic             ok;

    assign s_axis_tready = !q_full;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    always_comb begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        lbytes_next   = lbytes_reg;
        seq_left_next = seq_left_reg;
        int_left_next = int_left_reg;
        isel_next     = isel_reg;
        first_next    = first_reg;
        lz_next       = lz_reg;
        r_cnt_next    = r_cnt_reg;
        s_cnt_next    = s_cnt_reg;
        err_next      = err_reg;
        is_seq        = (phase_reg == PH_SEQ_LEN) || (phase_reg == PH_SEQ_LEN_MORE);
        fin_en        = 1'b0;
        fin_len       = '0;
        end_int       = 1'b0;
        emit          = 1'b0;
        emit_index    = '0;
        acc           = {accum_reg, b};
        il_dec        = int_left_reg - LEN_W'(1);
        lb_dec        = lbytes_reg - 4'd1;
        go            = 1'b1;
        cnt           = isel_reg ? s_cnt_reg : r_cnt_reg;

        if (!err_reg) begin
            if (phase_reg == PH_INT_TAG || phase_reg == PH_INT_LEN ||
                phase_reg == PH_INT_LEN_MORE || phase_reg == PH_INT_VAL ||
                phase_reg == PH_DONE) begin
                if (phase_reg == PH_DONE || seq_left_reg == '0) begin
                    err_next = 1'b1;
                    go       = 1'b0;
                end else begin
                    seq_left_next = seq_left_reg - LEN_W'(1);
                end
            end
            if (go) begin
                case (phase_reg)
                    PH_SEQ_TAG: begin
                        if (b == TAG_SEQUENCE) phase_next = PH_SEQ_LEN;
                        else err_next = 1'b1;
                    end
                    PH_INT_TAG: begin
                        if (b == TAG_INTEGER) phase_next = PH_INT_LEN;
                        else err_next = 1'b1;
                    end
                    PH_SEQ_LEN, PH_INT_LEN: begin
                        if (b == LEN_BAD_RESERVED || b == LEN_BAD_INDEF) begin
                            err_next = 1'b1;
                        end else if (!b[7]) begin
                            fin_en  = 1'b1;
                            fin_len = LEN_W'(b);
                        end else if (b[6:0] > LEN_LONG_MAX) begin
                            err_next = 1'b1;
                        end else begin
                            lbytes_next = b[3:0];
                            accum_next  = '0;
                            phase_next  = is_seq ? PH_SEQ_LEN_MORE : PH_INT_LEN_MORE;
                        end
                    end
                    PH_SEQ_LEN_MORE, PH_INT_LEN_MORE: begin
                        if (accum_reg == '0 && b == 8'd0) begin
                            err_next = 1'b1;
                        end else if (acc > LEN_BOUND) begin
                            err_next = 1'b1;
                        end else begin
                            accum_next  = acc[LEN_W-1:0];
                            lbytes_next = lb_dec;
                            if (lb_dec == 4'd0) begin
                                if (acc < LONG_FORM_MIN) begin
                                    err_next = 1'b1;
                                end else begin
                                    fin_en  = 1'b1;
                                    fin_len = acc[LEN_W-1:0];
                                end
                            end
                        end
                    end
                    PH_INT_VAL: begin
                        int_left_next = il_dec;
                        if (first_reg) begin
                            first_next = 1'b0;
                            if (b[7]) begin
                                err_next = 1'b1;
                                go       = 1'b0;
                            end else if (b == 8'd0) begin
                                go = 1'b0;
                                if (il_dec != '0) lz_next = 1'b1;
                                else end_int = 1'b1;
                            end
                        end else if (lz_reg) begin
                            lz_next = 1'b0;
                            if (!b[7]) begin
                                err_next = 1'b1;
                                go       = 1'b0;
                            end
                        end
                        if (go) begin
                            if (cnt == COUNT_MAX) begin
                                err_next = 1'b1;
                            end else begin
                                emit       = 1'b1;
                                emit_index = cnt;
                                if (isel_reg) s_cnt_next = cnt + 8'd1;
                                else r_cnt_next = cnt + 8'd1;
                                if (il_dec == '0) end_int = 1'b1;
                            end
                        end
                    end
                    default: begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end

        if (fin_en) begin
            if (is_seq) begin
                seq_left_next = fin_len;
                phase_next    = PH_INT_TAG;
            end else begin
                int_left_next = fin_len;
                first_next    = 1'b1;
                lz_next       = 1'b0;
                if (fin_len == '0) end_int = 1'b1;
                else phase_next = PH_INT_VAL;
            end
        end
        if (end_int) begin
            lz_next = 1'b0;
            if (!isel_reg) begin
                isel_next  = 1'b1;
                phase_next = PH_INT_TAG;
            end else begin
                phase_next = PH_DONE;
            end
        end

        ok = !err_next && phase_next == PH_DONE && seq_left_next == '0 &&
             r_cnt_next <= max_len_reg && s_cnt_next <= max_len_reg;

        q_rec.has_value   = emit;
        q_rec.is_s        = isel_reg;
        q_rec.value_byte  = b;
        q_rec.value_index = emit_index;
        q_rec.has_verdict = s_axis_tlast;
        q_rec.sig_ok      = ok;
        q_rec.r_length    = r_cnt_next;
        q_rec.s_length    = s_cnt_next;
        q_push            = fire && (emit || s_axis_tlast);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && s_axis_tlast)) begin
            phase_reg    <= PH_SEQ_TAG;
            accum_reg    <= '0;
            lbytes_reg   <= '0;
            seq_left_reg <= '0;
            int_left_reg <= '0;
            isel_reg     <= 1'b0;
            first_reg    <= 1'b1;
            lz_reg       <= 1'b0;
            r_cnt_reg    <= '0;
            s_cnt_reg    <= '0;
            err_reg      <= 1'b0;
        end else if (fire) begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            lbytes_reg   <= lbytes_next;
            seq_left_reg <= seq_left_next;
            int_left_reg <= int_left_next;
            isel_reg     <= isel_next;
            first_reg    <= first_next;
            lz_reg       <= lz_next;
            r_cnt_reg    <= r_cnt_next;
            s_cnt_reg    <= s_cnt_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_INT_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

endmodule

// ===== design/dersig_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dersig_queue
// Short FIFO of parse records between the parser and the beat emitter.
// ----------------------------------------------------------------------------
module dersig_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dersig_pkg::rec_t push_rec,
    input  logic             pop,
    output dersig_pkg::rec_t head_rec,
    output logic             empty,
    output logic             full
);
    import dersig_pkg::*;

    rec_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (QPTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/dersig_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dersig_back
// Beat emitter: turns queued records into value and verdict output beats.
// ----------------------------------------------------------------------------
module dersig_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dersig_pkg::rec_t                    head_rec,
    input  logic                                q_empty,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dersig_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [1:0]                          m_axis_tuser
);
    import dersig_pkg::*;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;
    logic [1:0]            m_tuser_reg;
    logic                  pend_reg;
    logic                  pend_ok_reg;
    logic [7:0]            pend_r_reg;
    logic [7:0]            pend_s_reg;
    logic                  out_free;

    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign q_pop    = out_free && !pend_reg && !q_empty;

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;
    assign m_axis_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else if (out_free) begin
            if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
                pend_reg     <= 1'b0;
            end else if (!q_empty) begin
                m_tvalid_reg <= 1'b1;
                pend_reg     <= head_rec.has_value && head_rec.has_verdict;
            end else begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // tdata: out_byte, value_index, sig_ok, r_length, s_length, zero pad
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_reg) begin
                m_tuser_reg <= KIND_VERDICT;
                m_tlast_reg <= 1'b1;
                m_tdata_reg <= OUT_DATA_W'({pend_s_reg, pend_r_reg, pend_ok_reg, 16'd0});
            end else if (!q_empty) begin
                pend_ok_reg <= head_rec.sig_ok;
                pend_r_reg  <= head_rec.r_length;
                pend_s_reg  <= head_rec.s_length;
                if (head_rec.has_value) begin
                    m_tuser_reg <= head_rec.is_s ? KIND_S : KIND_R;
                    m_tlast_reg <= !head_rec.has_verdict;
                    m_tdata_reg <= OUT_DATA_W'({head_rec.value_index, head_rec.value_byte});
                end else begin
                    m_tuser_reg <= KIND_VERDICT;
                    m_tlast_reg <= 1'b1;
                    m_tdata_reg <= OUT_DATA_W'({head_rec.s_length, head_rec.r_length,
                                                head_rec.sig_ok, 16'd0});
                end
            end
        end
    end

endmodule

// ===== design/der_signature_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// der_signature_parser
// Streaming DER ECDSA signature checker with r and s byte extraction.
// ----------------------------------------------------------------------------
// Input beats carry one signature byte in s_axis_tdata[7:0]; s_axis_tlast
// marks the final byte. Each byte gives at most one r or s value beat and the
// final byte also gives a verdict beat (m_axis_tuser = 2) carrying sig_ok and
// the r and s lengths. m_axis_tlast marks the last beat caused by one byte.
// Value beats of a signature whose verdict is 0 must be discarded.
// The parser takes one byte per cycle while the queue is not full; its state
// update completes in the cycle of acceptance and the record enters a
// four-entry queue. A result beat passes through the queue and then the
// output register. The emitter gives one beat per cycle while the receiver
// is ready, so a final byte that also carries a value gives two output beats.
// When the receiver stalls the queue fills and s_axis_tready drops once it
// holds four records; nothing is lost.
// Reset clears the parser, the queue and the output valid flag and loads
// max_int_len with 32. cfg_we writes cfg_wdata into max_int_len at once.
// ----------------------------------------------------------------------------
module der_signature_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // in_byte
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_byte[7:0], value_index[15:8], sig_ok[16], r_length[24:17],
    // s_length[32:25], zero [39:33]
    output logic [dersig_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [1:0]                          m_axis_tuser,  // out_kind
    input  logic                                cfg_we,
    input  logic [7:0]                          cfg_wdata
);
    import dersig_pkg::*;

    rec_t push_rec;
    rec_t head_rec;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;

    dersig_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_rec         (push_rec)
    );

    dersig_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    dersig_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_rec      (head_rec),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_verdict_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == KIND_VERDICT)
            |-> (m_axis_tlast && m_axis_tdata[15:0] == 16'd0))
        else $error("verdict beat malformed");

    a_value_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser != KIND_VERDICT)
            |-> (m_axis_tdata[32:16] == 17'd0 &&
                 (m_axis_tuser == KIND_R || m_axis_tuser == KIND_S)))
        else $error("value beat carries verdict fields");

    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_axis_tvalid)
        else $error("output valid straight after reset");

    a_ready_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push |-> !q_full))
        else $error("push into full queue");

endmodule

// ===== bench/der_signature_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// der_signature_parser_tb
// Self-checking bench for the streaming DER signature parser.
// ----------------------------------------------------------------------------
// Drives whole signatures, valid and broken, byte by byte with random bursts
// and gaps. A behavioural parser inside the bench predicts every r/s value
// beat and every verdict beat. Output beats are compared field by field in
// order. The receiver stalls on changing patterns and once holds off long
// enough to back the block up. max_int_len is rewritten between frames,
// the extremes included.
// ----------------------------------------------------------------------------
module der_signature_parser_tb;
    import dersig_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_BYTES  = 1200;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = 8'h00;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
        logic       ok;
        logic [7:0] r_len;
        logic [7:0] s_len;
        logic       last;
    } beat_t;

    beat_t pending_beats[$];

    // predictor state
    phase_t      parse_phase;
    int unsigned len_accum;
    int unsigned len_left;
    int unsigned seq_left;
    logic [15:0] int_left;
    logic        on_s;
    logic        first_val;
    logic        lead_zero;
    int unsigned r_seen;
    int unsigned s_seen;
    logic        reject_seen;
    logic [7:0]  max_len;

    int unsigned mismatches = 0;
    int unsigned beat_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;

    // receiver
    int          hold_req = 0;
    int          hold_left = 0;
    int          pattern_age = 0;
    logic [31:0] stall_mask = '1;

    der_signature_parser dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("der_signature_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        parse_phase = PH_SEQ_TAG;
        len_accum   = 0;
        len_left    = 0;
        seq_left    = 0;
        int_left    = '0;
        on_s        = 1'b0;
        first_val   = 1'b1;
        lead_zero   = 1'b0;
        r_seen      = 0;
        s_seen      = 0;
        reject_seen = 1'b0;
    endfunction

    function automatic void close_integer();
        lead_zero = 1'b0;
        if (!on_s) begin
            on_s = 1'b1;
            parse_phase = PH_INT_TAG;
        end else begin
            parse_phase = PH_DONE;
        end
    endfunction

    function automatic void take_length(int unsigned len, bit is_seq);
        if (is_seq) begin
            seq_left = len;
            parse_phase = PH_INT_TAG;
        end else begin
            int_left  = 16'(len);
            first_val = 1'b1;
            lead_zero = 1'b0;
            if (len == 0) close_integer();
            else parse_phase = PH_INT_VAL;
        end
    endfunction

    function automatic void first_len_byte(logic [7:0] b, bit is_seq);
        if (b == LEN_BAD_RESERVED || b == LEN_BAD_INDEF) begin
            reject_seen = 1'b1;
        end else if (!b[7]) begin
            take_length(b, is_seq);
        end else if (b[6:0] > LEN_LONG_MAX) begin
            reject_seen = 1'b1;
        end else begin
            len_left  = b[6:0];
            len_accum = 0;
            parse_phase = is_seq ? PH_SEQ_LEN_MORE : PH_INT_LEN_MORE;
        end
    endfunction

    function automatic void more_len_byte(logic [7:0] b, bit is_seq);
        int unsigned acc;
        if (len_accum == 0 && b == 8'h00) begin
            reject_seen = 1'b1;
            return;
        end
        acc = len_accum * 256 + b;
        if (acc > MAX_INPUT_BYTES) begin
            reject_seen = 1'b1;
            return;
        end
        len_accum = acc;
        len_left  = (len_left - 1) & 4'hF;
        if (len_left == 0) begin
            if (len_accum < 128) reject_seen = 1'b1;
            else take_length(len_accum, is_seq);
        end
    endfunction

    // returns 1 when the byte is an r or s value byte to be passed on
    function automatic bit parse_byte(logic [7:0] b, output logic is_s,
                                      output logic [7:0] idx);
        int unsigned cnt;
        is_s = 1'b0;
        idx  = '0;
        if (parse_phase >= PH_INT_TAG) begin
            if (parse_phase == PH_DONE || seq_left == 0) begin
                reject_seen = 1'b1;
                return 0;
            end
            seq_left--;
        end
        case (parse_phase)
            PH_SEQ_TAG: begin
                if (b == TAG_SEQUENCE) parse_phase = PH_SEQ_LEN;
                else reject_seen = 1'b1;
            end
            PH_SEQ_LEN:      first_len_byte(b, 1'b1);
            PH_SEQ_LEN_MORE: more_len_byte(b, 1'b1);
            PH_INT_TAG: begin
                if (b == TAG_INTEGER) parse_phase = PH_INT_LEN;
                else reject_seen = 1'b1;
            end
            PH_INT_LEN:      first_len_byte(b, 1'b0);
            PH_INT_LEN_MORE: more_len_byte(b, 1'b0);
            PH_INT_VAL: begin
                int_left = int_left - 16'd1;
                if (first_val) begin
                    first_val = 1'b0;
                    if (b[7]) begin
                        reject_seen = 1'b1;
                        return 0;
                    end
                    if (b == 8'h00) begin
                        if (int_left != 0) lead_zero = 1'b1;
                        else close_integer();
                        return 0;
                    end
                end else if (lead_zero) begin
                    lead_zero = 1'b0;
                    if (!b[7]) begin
                        reject_seen = 1'b1;
                        return 0;
                    end
                end
                cnt = on_s ? s_seen : r_seen;
                if (cnt >= COUNT_MAX) begin
                    reject_seen = 1'b1;
                    return 0;
                end
                is_s = on_s;
                idx  = 8'(cnt);
                if (on_s) s_seen++;
                else r_seen++;
                if (int_left == 0) close_integer();
                return 1;
            end
            default: reject_seen = 1'b1;
        endcase
        return 0;
    endfunction

    function automatic void predict_beats(logic [7:0] b, logic last);
        beat_t      v;
        logic       is_s;
        logic [7:0] idx;
        if (!reject_seen && parse_byte(b, is_s, idx)) begin
            v       = '0;
            v.kind  = is_s ? KIND_S : KIND_R;
            v.data  = b;
            v.index = idx;
            v.last  = !last;
            pending_beats.push_back(v);
        end
        if (last) begin
            v       = '0;
            v.kind  = KIND_VERDICT;
            v.ok    = !reject_seen && parse_phase == PH_DONE && seq_left == 0 &&
                      r_seen <= max_len && s_seen <= max_len;
            v.r_len = 8'(r_seen);
            v.s_len = 8'(s_seen);
            v.last  = 1'b1;
            pending_beats.push_back(v);
            clear_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // output checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [39:0] got, logic [39:0] want);
        $display("%0t: beat %0d %s got %0h expected %0h", $time, beat_count,
                 field, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        beat_t exp_beat;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata, '0);
            end else begin
                exp_beat = pending_beats.pop_front();
                if (m_axis_tuser !== exp_beat.kind)
                    report_mismatch("out_kind", m_axis_tuser, exp_beat.kind);
                if (m_axis_tdata[7:0] !== exp_beat.data)
                    report_mismatch("out_byte", m_axis_tdata[7:0], exp_beat.data);
                if (m_axis_tdata[15:8] !== exp_beat.index)
                    report_mismatch("value_index", m_axis_tdata[15:8], exp_beat.index);
                if (m_axis_tdata[16] !== exp_beat.ok)
                    report_mismatch("sig_ok", m_axis_tdata[16], exp_beat.ok);
                if (m_axis_tdata[24:17] !== exp_beat.r_len)
                    report_mismatch("r_length", m_axis_tdata[24:17], exp_beat.r_len);
                if (m_axis_tdata[32:25] !== exp_beat.s_len)
                    report_mismatch("s_length", m_axis_tdata[32:25], exp_beat.s_len);
                if (m_axis_tdata[39:33] !== 7'd0)
                    report_mismatch("tdata pad", m_axis_tdata[39:33], '0);
                if (m_axis_tlast !== exp_beat.last)
                    report_mismatch("run_last", m_axis_tlast, exp_beat.last);
            end
            beat_count++;
        end
    end

    // receiver: changing stall patterns, plus a counted hold-off on request
    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (pattern_age == 0) begin
                pattern_age = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       stall_mask = '1;
                    1:       stall_mask = $urandom;
                    2:       stall_mask = $urandom | $urandom;
                    default: stall_mask = $urandom & $urandom;
                endcase
                if (stall_mask == 0) stall_mask = 32'd1;
            end
            pattern_age--;
            m_axis_tready <= stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[31:1]};
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        predict_beats(b, last);
    endtask

    task automatic send_frame(logic [7:0] q[$]);
        foreach (q[i]) send_byte(q[i], i == q.size() - 1);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_len(logic [7:0] v);
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        max_len = v;
    endtask

    function automatic void put_length(ref logic [7:0] q[$], input int unsigned len);
        if (len < 128) begin
            q.push_back(8'(len));
        end else if (len < 256) begin
            q.push_back(8'h81);
            q.push_back(8'(len));
        end else begin
            q.push_back(8'h82);
            q.push_back(8'(len >> 8));
            q.push_back(8'(len));
        end
    endfunction

    // n value bytes after the strip; a first byte with its top bit set gets a zero
    function automatic void add_integer(ref logic [7:0] q[$], input int n);
        logic [7:0] body[$];
        body = {};
        if (n == 0) begin
            if ($urandom_range(0, 1)) body.push_back(8'h00);
        end else begin
            body.push_back(8'($urandom_range(1, 255)));
            for (int i = 1; i < n; i++) body.push_back(8'($urandom));
            if (body[0][7]) body.push_front(8'h00);
        end
        q.push_back(TAG_INTEGER);
        put_length(q, body.size());
        foreach (body[i]) q.push_back(body[i]);
    endfunction

    function automatic void build_signature(ref logic [7:0] q[$], input int nr, int ns);
        logic [7:0] content[$];
        content = {};
        add_integer(content, nr);
        add_integer(content, ns);
        q = {};
        q.push_back(TAG_SEQUENCE);
        put_length(q, content.size());
        foreach (content[i]) q.push_back(content[i]);
    endfunction

    function automatic void corrupt_frame(ref logic [7:0] q[$]);
        logic [7:0] odd_bytes[9] = '{8'h00, LEN_BAD_INDEF, LEN_BAD_RESERVED,
                                     TAG_SEQUENCE, TAG_INTEGER, 8'h81, 8'h82,
                                     8'h7F, 8'h89};
        int pos;
        int keep;
        pos = $urandom_range(0, q.size() - 1);
        case ($urandom_range(0, 4))
            0: q[pos] = 8'($urandom);
            1: q[pos] = odd_bytes[$urandom_range(0, 8)];
            2: begin
                keep = $urandom_range(1, q.size() > 1 ? q.size() - 1 : 1);
                while (q.size() > keep) q.delete(q.size() - 1);
            end
            3: repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
            default: q.insert(pos, odd_bytes[$urandom_range(0, 8)]);
        endcase
    endfunction

    function automatic int pick_int_len();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return $urandom_range(0, 36);
        if (sel < 18) return $urandom_range(37, 127);
        return $urandom_range(128, 250);
    endfunction

    // valid corner cases and one of each malformed case, under the reset limit of 32
    task automatic test_special_cases();
        logic [7:0] f[$];
        f = {TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h01, TAG_INTEGER, 8'h01, 8'h7F};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h07, TAG_INTEGER, 8'h02, 8'h00, 8'h80,
             TAG_INTEGER, 8'h01, 8'h00};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h04, TAG_INTEGER, 8'h00, TAG_INTEGER, 8'h00};
        send_frame(f);
        f = {8'h31};
        send_frame(f);
        f = {TAG_SEQUENCE, LEN_BAD_INDEF};
        send_frame(f);
        f = {TAG_SEQUENCE, LEN_BAD_RESERVED};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h89};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h81, 8'h00};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h81, 8'h7F};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h82, 8'h01, 8'h01};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h80, TAG_INTEGER, 8'h01, 8'h01};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h07, TAG_INTEGER, 8'h02, 8'h00, 8'h7F,
             TAG_INTEGER, 8'h01, 8'h01};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h01, TAG_INTEGER, 8'h01,
             8'h01, 8'h00};
        send_frame(f);
        f = {TAG_SEQUENCE, 8'h06, TAG_INTEGER, 8'h01, 8'h01};
        send_frame(f);
    endtask

    task automatic limit_pair(int nr, int ns);
        logic [7:0] f[$];
        build_signature(f, nr, ns);
        send_frame(f);
    endtask

    // starts on the reset value of the limit, then the extremes
    task automatic test_length_limit();
        limit_pair(32, 32);
        limit_pair(33, 1);
        limit_pair(2, 33);
        write_max_len(8'd0);
        limit_pair(0, 0);
        limit_pair(1, 0);
        limit_pair(0, 1);
        write_max_len(8'd1);
        limit_pair(1, 1);
        limit_pair(2, 1);
        write_max_len(8'd255);
        limit_pair(200, 1);
        limit_pair(130, 0);
        write_max_len(MAX_INT_LEN_RESET);
    endtask

    task automatic test_output_stall();
        wait_drained();
        hold_req = 400;
        repeat (4) limit_pair($urandom_range(3, 12), $urandom_range(3, 12));
        wait_drained();
    endtask

    task automatic test_random_signatures(int byte_budget);
        logic [7:0] f[$];
        int sent;
        int frames;
        sent   = 0;
        frames = 0;
        while (sent < byte_budget) begin
            if (frames % 24 == 23) begin
                case ($urandom_range(0, 3))
                    0:       write_max_len(8'd0);
                    1:       write_max_len(8'd255);
                    default: write_max_len(8'($urandom_range(0, 40)));
                endcase
            end
            build_signature(f, pick_int_len(), pick_int_len());
            case ($urandom_range(0, 9))
                6, 7, 8: corrupt_frame(f);
                9: begin
                    f = {};
                    repeat ($urandom_range(1, 10)) f.push_back(8'($urandom));
                    if ($urandom_range(0, 1)) f[0] = TAG_SEQUENCE;
                end
                default: ;
            endcase
            send_frame(f);
            sent += f.size();
            frames++;
        end
    endtask

    initial begin
        max_len = MAX_INT_LEN_RESET;
        clear_parser();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_special_cases();
        test_length_limit();
        test_output_stall();
        test_random_signatures(RANDOM_BYTES);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("der_signature_parser: match");
        end else begin
            $display("der_signature_parser: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/dersig_pkg.sv
design/dersig_front.sv
design/dersig_queue.sv
design/dersig_back.sv
design/der_signature_parser.sv
bench/der_signature_parser_tb.sv
